@@ sv/psd_pkg.sv @@
// ---------------------------------------------------------------------------
// psd_pkg
// Shared types and codes for the power source detector with debounce.
// ---------------------------------------------------------------------------
package psd_pkg;

  typedef enum logic [1:0] {
    SRC_UNKNOWN = 2'd0,
    SRC_GRID    = 2'd1,
    SRC_GEN     = 2'd2
  } src_t;

  typedef enum logic [3:0] {
    RSN_NONE           = 4'd0,
    RSN_NOT_CONFIGURED = 4'd1,
    RSN_INVALID        = 4'd2,
    RSN_UNAVAILABLE    = 4'd3,
    RSN_STALE          = 4'd4,
    RSN_NON_FINITE     = 4'd5,
    RSN_UNKNOWN_VALUE  = 4'd6,
    RSN_CONFLICT       = 4'd7,
    RSN_NO_SOURCE      = 4'd8,
    RSN_PENDING        = 4'd9
  } reason_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_DUAL   = 2'd2,
    MODE_BAD    = 2'd3
  } mode_t;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_DETECT_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TIME   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STALE_LIMIT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GRID_WORD       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GENERATOR_WORD  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GRID_LIMIT      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_GENERATOR_LIMIT = 3'd6;

  typedef struct packed {
    mode_t              detect_mode;
    logic [31:0]        debounce_time;
    logic [31:0]        stale_limit;
    logic [15:0]        grid_word;
    logic [15:0]        generator_word;
    logic signed [31:0] grid_limit;
    logic signed [31:0] generator_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_time;
    logic               single_present;
    logic [31:0]        single_age;
    logic [15:0]        single_raw;
    logic               grid_present;
    logic [31:0]        grid_age;
    logic signed [31:0] grid_power;
    logic               grid_finite;
    logic               gen_present;
    logic [31:0]        gen_age;
    logic signed [31:0] gen_power;
    logic               gen_finite;
  } sample_t;

  typedef struct packed {
    src_t    cand;
    reason_t reason;
    logic    fresh;
  } verdict_t;

  typedef struct packed {
    src_t    source_state;
    src_t    candidate;
    reason_t reason_code;
    src_t    tariff_sel;
    logic    fresh_flag;
    logic    conflict_flag;
    logic    pending_flag;
    logic    control_ok;
    logic    fail_safe;
  } result_t;

endpackage

@@ sv/power_source_detect_debounce.sv @@
// ---------------------------------------------------------------------------
// power_source_detect_debounce
// Supply source detector (grid / generator / unknown) with time debounce.
// ---------------------------------------------------------------------------
// usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high, so a write lands at the edge where cfg_valid is high.
//   write registers only while no sample is in flight
//   input channel: in_valid/in_stall, one evidence sample per word
//   output channel: out_valid/out_stall, one result word per sample
//   latency: a sample accepted at edge n shows its result after edge n+1
//   throughput: one sample per cycle, set by the single pass of
//   classification plus the 32-bit elapsed-time compare between the input
//   register and the result register
//   stall: while out_stall holds a full result register, the input register
//   fills and then in_stall rises in the same cycle; the result word holds
//   reset: synchronous, clears pipeline valids, the debounce memory and the
//   config registers to their defaults; no clearing pass is needed
// ---------------------------------------------------------------------------
module power_source_detect_debounce import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  // input sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        now_time,
  input  logic               single_present,
  input  logic [31:0]        single_age,
  input  logic [15:0]        single_raw,
  input  logic               grid_present,
  input  logic [31:0]        grid_age,
  input  logic signed [31:0] grid_power,
  input  logic               grid_finite,
  input  logic               gen_present,
  input  logic [31:0]        gen_age,
  input  logic signed [31:0] gen_power,
  input  logic               gen_finite,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         source_state,
  output logic [1:0]         candidate,
  output logic [3:0]         reason_code,
  output logic [1:0]         tariff_sel,
  output logic               fresh_flag,
  output logic               conflict_flag,
  output logic               pending_flag,
  output logic               control_ok,
  output logic               fail_safe
);

  cfg_t     cfg;
  sample_t  smp;        // input register payload
  logic     smp_valid;
  verdict_t verdict;
  result_t  result;
  result_t  res;        // result register payload
  logic     res_free;   // result register can take a word this cycle
  logic     advance;    // sample moves from input to result register

  psd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake control
  assign res_free = !out_valid || !out_stall;
  assign advance  = smp_valid && res_free;
  assign in_stall = smp_valid && !res_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!in_stall) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp.now_time       <= now_time;
      smp.single_present <= single_present;
      smp.single_age     <= single_age;
      smp.single_raw     <= single_raw;
      smp.grid_present   <= grid_present;
      smp.grid_age       <= grid_age;
      smp.grid_power     <= grid_power;
      smp.grid_finite    <= grid_finite;
      smp.gen_present    <= gen_present;
      smp.gen_age        <= gen_age;
      smp.gen_power      <= gen_power;
      smp.gen_finite     <= gen_finite;
    end
  end

  // classification and debounce, one pass
  psd_classify u_classify (
    .cfg     (cfg),
    .smp     (smp),
    .verdict (verdict)
  );

  psd_debounce u_debounce (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .verdict       (verdict),
    .now_time      (smp.now_time),
    .debounce_time (cfg.debounce_time),
    .result        (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

  assign source_state  = res.source_state;
  assign candidate     = res.candidate;
  assign reason_code   = res.reason_code;
  assign tariff_sel    = res.tariff_sel;
  assign fresh_flag    = res.fresh_flag;
  assign conflict_flag = res.conflict_flag;
  assign pending_flag  = res.pending_flag;
  assign control_ok    = res.control_ok;
  assign fail_safe     = res.fail_safe;

  // a pending result never grants control and always carries the pending reason
  a_pending_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && pending_flag |-> !control_ok && reason_code == RSN_PENDING)
    else $error("pending result grants control");

  // control is granted only with a known candidate that agrees with the state
  a_control_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && control_ok |-> candidate == source_state && reason_code == RSN_NONE)
    else $error("control granted without matching candidate");

  // the input stalls only while it holds a sample and the output is valid and stalled
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> smp_valid && out_valid && out_stall)
    else $error("input stalled without a blocked output");

endmodule

@@ sv/psd_cfg.sv @@
// ---------------------------------------------------------------------------
// psd_cfg
// Configuration register file, written through a valid/ready channel.
// ---------------------------------------------------------------------------
module psd_cfg import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_mode     <= MODE_OFF;
      cfg.debounce_time   <= 32'd0;
      cfg.stale_limit     <= 32'd0;
      cfg.grid_word       <= 16'd0;
      cfg.generator_word  <= 16'd1;
      cfg.grid_limit      <= 32'sd0;
      cfg.generator_limit <= 32'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DETECT_MODE:     cfg.detect_mode     <= mode_t'(cfg_data[1:0]);
        CFG_DEBOUNCE_TIME:   cfg.debounce_time   <= cfg_data;
        CFG_STALE_LIMIT:     cfg.stale_limit     <= cfg_data;
        CFG_GRID_WORD:       cfg.grid_word       <= cfg_data[15:0];
        CFG_GENERATOR_WORD:  cfg.generator_word  <= cfg_data[15:0];
        CFG_GRID_LIMIT:      cfg.grid_limit      <= $signed(cfg_data);
        CFG_GENERATOR_LIMIT: cfg.generator_limit <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

@@ sv/psd_classify.sv @@
// ---------------------------------------------------------------------------
// psd_classify
// Classifies one evidence sample as grid, generator or unknown.
// ---------------------------------------------------------------------------
module psd_classify import psd_pkg::*; (
  input  cfg_t     cfg,
  input  sample_t  smp,
  output verdict_t verdict
);

  logic g_act;
  logic q_act;

  assign g_act = $signed(smp.grid_power) > $signed(cfg.grid_limit);
  assign q_act = $signed(smp.gen_power) > $signed(cfg.generator_limit);

  always_comb begin
    verdict = '{cand: SRC_UNKNOWN, reason: RSN_INVALID, fresh: 1'b0};
    if (cfg.detect_mode == MODE_OFF) begin
      verdict.reason = RSN_NOT_CONFIGURED;
    end else if (cfg.debounce_time == 32'd0 || cfg.stale_limit == 32'd0) begin
      verdict.reason = RSN_INVALID;
    end else if (cfg.detect_mode == MODE_SINGLE) begin
      if (cfg.grid_word == cfg.generator_word) begin
        verdict.reason = RSN_INVALID;
      end else if (!smp.single_present) begin
        verdict.reason = RSN_UNAVAILABLE;
      end else if (smp.single_age > cfg.stale_limit) begin
        verdict.reason = RSN_STALE;
      end else begin
        verdict.fresh  = 1'b1;
        verdict.reason = RSN_NONE;
        if (cfg.grid_word == 16'd0) begin
          // bitmask rule: zero is grid, anything else generator
          verdict.cand = (smp.single_raw == 16'd0) ? SRC_GRID : SRC_GEN;
        end else if (smp.single_raw == cfg.grid_word) begin
          verdict.cand = SRC_GRID;
        end else if (smp.single_raw == cfg.generator_word) begin
          verdict.cand = SRC_GEN;
        end else begin
          verdict.reason = RSN_UNKNOWN_VALUE;
        end
      end
    end else if (cfg.detect_mode == MODE_DUAL) begin
      if (!($signed(cfg.grid_limit) > 32'sd0) ||
          !($signed(cfg.generator_limit) > 32'sd0)) begin
        verdict.reason = RSN_INVALID;
      end else if (!smp.grid_present || !smp.gen_present) begin
        verdict.reason = RSN_UNAVAILABLE;
      end else if (smp.grid_age > cfg.stale_limit || smp.gen_age > cfg.stale_limit) begin
        verdict.reason = RSN_STALE;
      end else if (!smp.grid_finite || !smp.gen_finite) begin
        verdict.reason = RSN_NON_FINITE;
      end else if (g_act && q_act) begin
        verdict.reason = RSN_CONFLICT;
      end else if (!g_act && !q_act) begin
        verdict.reason = RSN_NO_SOURCE;
      end else begin
        verdict.cand   = g_act ? SRC_GRID : SRC_GEN;
        verdict.reason = RSN_NONE;
        verdict.fresh  = 1'b1;
      end
    end
  end

endmodule

@@ sv/psd_debounce.sv @@
// ---------------------------------------------------------------------------
// psd_debounce
// Debounce memory and result assembly for one classified sample.
// ---------------------------------------------------------------------------
module psd_debounce import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  verdict_t    verdict,
  input  logic [31:0] now_time,
  input  logic [31:0] debounce_time,
  output result_t     result
);

  src_t        stable_src, stable_src_next;
  logic        pend_valid, pend_valid_next;
  src_t        pend_src, pend_src_next;
  logic [31:0] pend_start, pend_start_next;

  logic        restart;
  logic [31:0] start_eff;
  logic [31:0] elapsed;
  src_t        state;
  reason_t     reason;
  logic        pending;

  assign restart   = !pend_valid || (pend_src != verdict.cand);
  assign start_eff = restart ? now_time : pend_start;
  assign elapsed   = now_time - start_eff;

  always_comb begin
    stable_src_next = stable_src;
    pend_valid_next = pend_valid;
    pend_src_next   = pend_src;
    pend_start_next = pend_start;
    state           = SRC_UNKNOWN;
    reason          = verdict.reason;
    pending         = 1'b0;
    if (verdict.cand == SRC_UNKNOWN) begin
      stable_src_next = SRC_UNKNOWN;
      pend_valid_next = 1'b0;
      pend_src_next   = SRC_UNKNOWN;
      pend_start_next = 32'd0;
    end else if (!pend_valid && stable_src == verdict.cand) begin
      state  = stable_src;
      reason = RSN_NONE;
    end else if (elapsed >= debounce_time) begin
      stable_src_next = verdict.cand;
      pend_valid_next = 1'b0;
      pend_src_next   = SRC_UNKNOWN;
      pend_start_next = 32'd0;
      state           = verdict.cand;
      reason          = RSN_NONE;
    end else begin
      pend_valid_next = 1'b1;
      pend_src_next   = verdict.cand;
      pend_start_next = start_eff;
      if (restart) begin
        stable_src_next = SRC_UNKNOWN;
      end
      reason  = RSN_PENDING;
      pending = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_src <= SRC_UNKNOWN;
      pend_valid <= 1'b0;
      pend_src   <= SRC_UNKNOWN;
      pend_start <= 32'd0;
    end else if (advance) begin
      stable_src <= stable_src_next;
      pend_valid <= pend_valid_next;
      pend_src   <= pend_src_next;
      pend_start <= pend_start_next;
    end
  end

  always_comb begin
    result.source_state  = state;
    result.candidate     = verdict.cand;
    result.reason_code   = reason;
    result.tariff_sel    = state;
    result.fresh_flag    = verdict.fresh;
    result.conflict_flag = (verdict.reason == RSN_CONFLICT);
    result.pending_flag  = pending;
    result.control_ok    = (state != SRC_UNKNOWN);
    result.fail_safe     = (state == SRC_UNKNOWN);
  end

endmodule

@@ tb/sv/power_source_detect_debounce_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// power_source_detect_debounce_checker
// Follows the config, sample and result channels of the source detector,
// predicts every result word from its own copy of the registers and the
// debounce memory, and compares each returned word field by field.
// ---------------------------------------------------------------------------
module power_source_detect_debounce_checker import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        now_time,
  input  logic               single_present,
  input  logic [31:0]        single_age,
  input  logic [15:0]        single_raw,
  input  logic               grid_present,
  input  logic [31:0]        grid_age,
  input  logic signed [31:0] grid_power,
  input  logic               grid_finite,
  input  logic               gen_present,
  input  logic [31:0]        gen_age,
  input  logic signed [31:0] gen_power,
  input  logic               gen_finite,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         source_state,
  input  logic [1:0]         candidate,
  input  logic [3:0]         reason_code,
  input  logic [1:0]         tariff_sel,
  input  logic               fresh_flag,
  input  logic               conflict_flag,
  input  logic               pending_flag,
  input  logic               control_ok,
  input  logic               fail_safe,
  output int                 fail_count,
  output int                 words_due
);

  cfg_t        regs;
  src_t        held_src;
  logic        wait_valid;
  src_t        wait_src;
  logic [31:0] wait_start;

  result_t     owed_results[$];
  result_t     want;
  sample_t     word_in;

  function automatic verdict_t classify_evidence(input sample_t s);
    verdict_t v;
    logic     g_on;
    logic     q_on;
    v.cand   = SRC_UNKNOWN;
    v.reason = RSN_INVALID;
    v.fresh  = 1'b0;
    g_on = $signed(s.grid_power) > $signed(regs.grid_limit);
    q_on = $signed(s.gen_power) > $signed(regs.generator_limit);
    if (regs.detect_mode == MODE_OFF) begin
      v.reason = RSN_NOT_CONFIGURED;
    end else if (regs.debounce_time == 32'd0 || regs.stale_limit == 32'd0) begin
      v.reason = RSN_INVALID;
    end else if (regs.detect_mode == MODE_SINGLE) begin
      if (regs.grid_word == regs.generator_word) begin
        v.reason = RSN_INVALID;
      end else if (!s.single_present) begin
        v.reason = RSN_UNAVAILABLE;
      end else if (s.single_age > regs.stale_limit) begin
        v.reason = RSN_STALE;
      end else begin
        v.fresh  = 1'b1;
        v.reason = RSN_NONE;
        if (regs.grid_word == 16'd0) begin
          v.cand = (s.single_raw == 16'd0) ? SRC_GRID : SRC_GEN;
        end else if (s.single_raw == regs.grid_word) begin
          v.cand = SRC_GRID;
        end else if (s.single_raw == regs.generator_word) begin
          v.cand = SRC_GEN;
        end else begin
          v.reason = RSN_UNKNOWN_VALUE;
        end
      end
    end else if (regs.detect_mode == MODE_DUAL) begin
      if (!($signed(regs.grid_limit) > 0) || !($signed(regs.generator_limit) > 0)) begin
        v.reason = RSN_INVALID;
      end else if (!s.grid_present || !s.gen_present) begin
        v.reason = RSN_UNAVAILABLE;
      end else if (s.grid_age > regs.stale_limit || s.gen_age > regs.stale_limit) begin
        v.reason = RSN_STALE;
      end else if (!s.grid_finite || !s.gen_finite) begin
        v.reason = RSN_NON_FINITE;
      end else if (g_on && q_on) begin
        v.reason = RSN_CONFLICT;
      end else if (!g_on && !q_on) begin
        v.reason = RSN_NO_SOURCE;
      end else begin
        v.cand   = g_on ? SRC_GRID : SRC_GEN;
        v.reason = RSN_NONE;
        v.fresh  = 1'b1;
      end
    end
    return v;
  endfunction

  // classification plus the debounce memory update
  function automatic result_t resolve_source(input sample_t s);
    verdict_t    v;
    result_t     r;
    src_t        state;
    logic [31:0] elapsed;
    v = classify_evidence(s);
    r = '0;
    r.candidate     = v.cand;
    r.fresh_flag    = v.fresh;
    r.conflict_flag = (v.reason == RSN_CONFLICT);
    r.reason_code   = RSN_NONE;
    state = SRC_UNKNOWN;
    if (v.cand == SRC_UNKNOWN) begin
      held_src      = SRC_UNKNOWN;
      wait_valid    = 1'b0;
      wait_src      = SRC_UNKNOWN;
      wait_start    = 32'd0;
      r.reason_code = v.reason;
    end else if (!wait_valid && held_src == v.cand) begin
      state = held_src;
    end else begin
      if (!wait_valid || wait_src != v.cand) begin
        wait_valid = 1'b1;
        wait_src   = v.cand;
        wait_start = s.now_time;
        held_src   = SRC_UNKNOWN;
      end
      elapsed = s.now_time - wait_start;
      if (elapsed >= regs.debounce_time) begin
        held_src   = v.cand;
        wait_valid = 1'b0;
        wait_src   = SRC_UNKNOWN;
        wait_start = 32'd0;
        state      = held_src;
      end else begin
        r.reason_code  = RSN_PENDING;
        r.pending_flag = 1'b1;
      end
    end
    r.source_state = state;
    r.tariff_sel   = state;
    r.control_ok   = (state != SRC_UNKNOWN);
    r.fail_safe    = (state == SRC_UNKNOWN);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] exp_val,
                                      input logic [3:0] got_val);
    if (got_val !== exp_val) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.detect_mode     = MODE_OFF;
      regs.debounce_time   = 32'd0;
      regs.stale_limit     = 32'd0;
      regs.grid_word       = 16'd0;
      regs.generator_word  = 16'd1;
      regs.grid_limit      = 32'sd0;
      regs.generator_limit = 32'sd0;
      held_src   = SRC_UNKNOWN;
      wait_valid = 1'b0;
      wait_src   = SRC_UNKNOWN;
      wait_start = 32'd0;
      fail_count = 0;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DETECT_MODE:     regs.detect_mode     = mode_t'(cfg_data[1:0]);
          CFG_DEBOUNCE_TIME:   regs.debounce_time   = cfg_data;
          CFG_STALE_LIMIT:     regs.stale_limit     = cfg_data;
          CFG_GRID_WORD:       regs.grid_word       = cfg_data[15:0];
          CFG_GENERATOR_WORD:  regs.generator_word  = cfg_data[15:0];
          CFG_GRID_LIMIT:      regs.grid_limit      = cfg_data;
          CFG_GENERATOR_LIMIT: regs.generator_limit = cfg_data;
          default: ;
        endcase
      end
      // results first, so a word can never meet its own prediction in one edge
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected, state %0d reason %0d",
                   $time, source_state, reason_code);
        end else begin
          want = owed_results.pop_front();
          check_field("source_state", 4'(want.source_state), 4'(source_state));
          check_field("candidate", 4'(want.candidate), 4'(candidate));
          check_field("reason_code", want.reason_code, reason_code);
          check_field("tariff_sel", 4'(want.tariff_sel), 4'(tariff_sel));
          check_field("fresh_flag", 4'(want.fresh_flag), 4'(fresh_flag));
          check_field("conflict_flag", 4'(want.conflict_flag), 4'(conflict_flag));
          check_field("pending_flag", 4'(want.pending_flag), 4'(pending_flag));
          check_field("control_ok", 4'(want.control_ok), 4'(control_ok));
          check_field("fail_safe", 4'(want.fail_safe), 4'(fail_safe));
        end
      end
      if (in_valid && !in_stall) begin
        word_in = {now_time, single_present, single_age, single_raw, grid_present,
                   grid_age, grid_power, grid_finite, gen_present, gen_age,
                   gen_power, gen_finite};
        owed_results.push_back(resolve_source(word_in));
      end
    end
    words_due = owed_results.size();
  end

endmodule

@@ tb/sv/power_source_detect_debounce_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// power_source_detect_debounce_tb
// Drives evidence words and register writes into the source detector: a
// directed walk through every reason code, then random runs of mostly consistent
// evidence under changing settings and idle/stall phases. A separate checker
// predicts and compares; this module only stimulates and gives the verdict.
// ---------------------------------------------------------------------------
module power_source_detect_debounce_tb;
  import psd_pkg::*;

  // cycles with no handshake on any channel before the run is declared hung
  localparam int QuietLimit = 2000;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index      = '0;
  logic [31:0]        cfg_data       = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [31:0]        now_time       = '0;
  logic               single_present = 1'b0;
  logic [31:0]        single_age     = '0;
  logic [15:0]        single_raw     = '0;
  logic               grid_present   = 1'b0;
  logic [31:0]        grid_age       = '0;
  logic signed [31:0] grid_power     = '0;
  logic               grid_finite    = 1'b0;
  logic               gen_present    = 1'b0;
  logic [31:0]        gen_age        = '0;
  logic signed [31:0] gen_power      = '0;
  logic               gen_finite     = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         source_state;
  logic [1:0]         candidate;
  logic [3:0]         reason_code;
  logic [1:0]         tariff_sel;
  logic               fresh_flag;
  logic               conflict_flag;
  logic               pending_flag;
  logic               control_ok;
  logic               fail_safe;

  int                 fail_count;
  int                 words_due;

  // stimulus shaping state
  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct     = 0;
  int                 quiet_cycles  = 0;
  cfg_t               setting;
  logic [31:0]        clock_ms      = 32'd0;
  int unsigned        step_ms       = 50;
  src_t               aim           = SRC_GRID;

  power_source_detect_debounce u_top (.*);

  power_source_detect_debounce_checker u_checker (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) out_stall <= ($urandom_range(99, 0) < stall_pct);

  // hang detector: any accepted word on any channel resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("power_source_detect_debounce_tb failed");
        $finish;
      end
    end
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // one register write; valid drops after the handshake
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off the sender until every predicted result word has come back
  task automatic settle();
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
  endtask

  // present one evidence word, with random idle cycles in front of it;
  // valid stays high on return so back-to-back words have no gap
  task automatic send_sample(input sample_t s);
    while (chance(send_idle_pct)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    now_time       = s.now_time;
    single_present = s.single_present;
    single_age     = s.single_age;
    single_raw     = s.single_raw;
    grid_present   = s.grid_present;
    grid_age       = s.grid_age;
    grid_power     = s.grid_power;
    grid_finite    = s.grid_finite;
    gen_present    = s.gen_present;
    gen_age        = s.gen_age;
    gen_power      = s.gen_power;
    gen_finite     = s.gen_finite;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic apply_setting(input cfg_t c);
    write_reg(CFG_DETECT_MODE, {30'd0, c.detect_mode});
    write_reg(CFG_DEBOUNCE_TIME, c.debounce_time);
    write_reg(CFG_STALE_LIMIT, c.stale_limit);
    write_reg(CFG_GRID_WORD, {16'd0, c.grid_word});
    write_reg(CFG_GENERATOR_WORD, {16'd0, c.generator_word});
    write_reg(CFG_GRID_LIMIT, c.grid_limit);
    write_reg(CFG_GENERATOR_LIMIT, c.generator_limit);
  endtask

  // directed words: fields of the unused mode stay at zero
  function automatic sample_t single_word(input logic [31:0] t, input logic present,
                                          input logic [31:0] age, input logic [15:0] raw);
    sample_t s;
    s = '0;
    s.now_time       = t;
    s.single_present = present;
    s.single_age     = age;
    s.single_raw     = raw;
    return s;
  endfunction

  function automatic sample_t meter_word(input logic [31:0] t,
      input logic gp, input logic [31:0] ga, input logic [31:0] gpow, input logic gf,
      input logic qp, input logic [31:0] qa, input logic [31:0] qpow, input logic qf);
    sample_t s;
    s = '0;
    s.now_time     = t;
    s.grid_present = gp;
    s.grid_age     = ga;
    s.grid_power   = gpow;
    s.grid_finite  = gf;
    s.gen_present  = qp;
    s.gen_age      = qa;
    s.gen_power    = qpow;
    s.gen_finite   = qf;
    return s;
  endfunction

  // threshold: mostly a sane positive level, sometimes zero, negative or the top
  function automatic logic signed [31:0] random_limit();
    if (chance(4)) return 32'sd0;
    if (chance(4)) return 32'h8000_0000 | $urandom;
    if (chance(8)) return 32'sh7fff_ffff;
    return $urandom_range(32'h0010_0000, 1);
  endfunction

  function automatic cfg_t random_setting();
    cfg_t        c;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    c.detect_mode = (pick < 5) ? MODE_OFF : (pick < 10) ? MODE_BAD :
                    (pick < 55) ? MODE_SINGLE : MODE_DUAL;
    c.debounce_time = chance(4) ? 32'd0 : chance(10) ? 32'hffff_ffff :
                      $urandom_range(40, 1);
    c.stale_limit = chance(4) ? 32'd0 : chance(10) ? 32'hffff_ffff :
                    $urandom_range(500, 1);
    // zero grid word selects the bitmask rule
    c.grid_word = chance(35) ? 16'd0 : chance(10) ? 16'hffff :
                  16'($urandom_range(65535, 1));
    c.generator_word = chance(5) ? c.grid_word : chance(8) ? 16'd0 :
                       chance(8) ? 16'hffff : 16'($urandom_range(65535, 0));
    c.grid_limit      = random_limit();
    c.generator_limit = random_limit();
    return c;
  endfunction

  // ages hug the stale boundary now and then
  function automatic logic [31:0] evidence_age();
    if (chance(5)) return setting.stale_limit;
    if (chance(5)) return setting.stale_limit + 32'd1;
    if (chance(4)) return $urandom;
    return $urandom_range(setting.stale_limit, 0);
  endfunction

  function automatic logic signed [31:0] above_limit(input logic signed [31:0] lim);
    logic signed [31:0] p;
    p = lim + 32'sd1 + $urandom_range(4095, 0);
    if (p <= lim) p = 32'sh7fff_ffff;  // no room above: saturate
    return p;
  endfunction

  function automatic logic signed [31:0] below_limit(input logic signed [31:0] lim);
    logic signed [31:0] p;
    p = lim - $urandom_range(4095, 0);
    if (p > lim) p = 32'sh8000_0000;
    return p;
  endfunction

  // mostly consistent evidence for the source being aimed at, so candidates
  // hold long enough to settle; single fields go bad now and then
  function automatic sample_t random_sample();
    sample_t s;
    logic    g_on;
    logic    q_on;
    if (chance(3)) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(step_ms, 0);
    if (chance(8)) aim = chance(50) ? SRC_GRID : SRC_GEN;
    s.now_time = clock_ms;
    // single input evidence
    s.single_present = !chance(4);
    s.single_age     = evidence_age();
    if (chance(8)) s.single_raw = 16'($urandom_range(65535, 0));
    else if (setting.grid_word == 16'd0) begin
      if (aim == SRC_GRID) s.single_raw = 16'd0;
      else s.single_raw = 16'($urandom_range(65535, 1));
    end else begin
      s.single_raw = (aim == SRC_GRID) ? setting.grid_word : setting.generator_word;
    end
    // meter evidence, with the odd conflict or dead supply
    g_on = (aim == SRC_GRID);
    q_on = !g_on;
    if (chance(6)) begin
      g_on = 1'b1;
      q_on = 1'b1;
    end else if (chance(6)) begin
      g_on = 1'b0;
      q_on = 1'b0;
    end
    s.grid_present = !chance(4);
    s.grid_age     = evidence_age();
    s.grid_finite  = !chance(4);
    s.grid_power   = chance(6) ? $urandom : g_on ? above_limit(setting.grid_limit) :
                     below_limit(setting.grid_limit);
    s.gen_present  = !chance(4);
    s.gen_age      = evidence_age();
    s.gen_finite   = !chance(4);
    s.gen_power    = chance(6) ? $urandom : q_on ? above_limit(setting.generator_limit) :
                     below_limit(setting.generator_limit);
    return s;
  endfunction

  initial begin
    int sent;
    int n;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    // registers at reset: detector disabled
    send_sample(single_word(32'd10, 1'b1, 32'd0, 16'd0));
    settle();
    write_reg(CFG_DETECT_MODE, {30'd0, MODE_SINGLE});
    write_reg(CFG_DEBOUNCE_TIME, 32'd0);
    write_reg(CFG_STALE_LIMIT, 32'd10);
    // zero debounce time is a bad setting
    send_sample(single_word(32'd20, 1'b1, 32'd0, 16'd0));
    settle();
    write_reg(CFG_DEBOUNCE_TIME, 32'd5);
    write_reg(CFG_STALE_LIMIT, 32'd0);
    // zero stale limit likewise
    send_sample(single_word(32'd30, 1'b1, 32'd0, 16'd0));
    settle();
    write_reg(CFG_STALE_LIMIT, 32'd100);
    write_reg(CFG_GRID_WORD, 32'h0000_00a5);
    write_reg(CFG_GENERATOR_WORD, 32'h0000_00a5);
    // grid and generator words equal
    send_sample(single_word(32'd35, 1'b1, 32'd0, 16'h00a5));
    settle();
    write_reg(CFG_GENERATOR_WORD, 32'h0000_ffff);
    send_sample(single_word(32'd40, 1'b0, 32'd0, 16'h00a5));     // no sample
    send_sample(single_word(32'd41, 1'b1, 32'd101, 16'h00a5));   // one past stale limit
    send_sample(single_word(32'd42, 1'b1, 32'd100, 16'h1234));   // no match, still fresh
    send_sample(single_word(32'd1000, 1'b1, 32'd0, 16'h00a5));   // grid starts debounce
    send_sample(single_word(32'd1005, 1'b1, 32'd100, 16'h00a5)); // held long enough
    send_sample(single_word(32'd1006, 1'b1, 32'd0, 16'hffff));   // switch to generator
    send_sample(single_word(32'd1007, 1'b1, 32'd0, 16'h1234));   // unknown clears memory
    settle();
    // bitmask rule, debounce across the 32-bit wrap of the ms counter
    write_reg(CFG_GRID_WORD, 32'd0);
    send_sample(single_word(32'hffff_fffe, 1'b1, 32'd0, 16'h0000));
    send_sample(single_word(32'hffff_ffff, 1'b1, 32'd0, 16'hffff));
    send_sample(single_word(32'd4, 1'b1, 32'd0, 16'h8000));
    send_sample(single_word(32'd5, 1'b1, 32'd0, 16'h0001));
    settle();
    write_reg(CFG_DETECT_MODE, {30'd0, MODE_DUAL});
    write_reg(CFG_DEBOUNCE_TIME, 32'd1);
    write_reg(CFG_GRID_LIMIT, 32'd0);
    write_reg(CFG_GENERATOR_LIMIT, 32'h0002_0000);
    // grid threshold zero
    send_sample(meter_word(32'd50, 1'b1, 32'd0, 32'h0002_0000, 1'b1,
                           1'b1, 32'd0, 32'd0, 1'b1));
    settle();
    write_reg(CFG_GRID_LIMIT, 32'h0001_0000);
    write_reg(CFG_GENERATOR_LIMIT, 32'h8000_0000);
    // generator threshold most negative
    send_sample(meter_word(32'd50, 1'b1, 32'd0, 32'h0002_0000, 1'b1,
                           1'b1, 32'd0, 32'd0, 1'b1));
    settle();
    write_reg(CFG_GENERATOR_LIMIT, 32'h0002_0000);
    send_sample(meter_word(32'd51, 1'b0, 32'd0, 32'h0002_0000, 1'b1,  // grid meter missing
                           1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(meter_word(32'd52, 1'b1, 32'd0, 32'h0002_0000, 1'b1,  // generator stale
                           1'b1, 32'd101, 32'd0, 1'b1));
    send_sample(meter_word(32'd53, 1'b1, 32'd0, 32'h0002_0000, 1'b0,  // non-finite grid
                           1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(meter_word(32'd54, 1'b1, 32'd0, 32'h0002_0000, 1'b1,  // both running
                           1'b1, 32'd0, 32'h0003_0000, 1'b1));
    send_sample(meter_word(32'd55, 1'b1, 32'd0, 32'h8000_0000, 1'b1,  // neither, one at limit
                           1'b1, 32'd100, 32'h0002_0000, 1'b1));
    send_sample(meter_word(32'd60, 1'b1, 32'd0, 32'h0001_0001, 1'b1,  // grid just above
                           1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(meter_word(32'd61, 1'b1, 32'd0, 32'h0001_0001, 1'b1,
                           1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(meter_word(32'd62, 1'b1, 32'd0, 32'h0001_0000, 1'b1,  // generator at full scale
                           1'b1, 32'd0, 32'h7fff_ffff, 1'b1));
    settle();
    // debounce time, stale limit and grid threshold at their top values
    write_reg(CFG_DEBOUNCE_TIME, 32'hffff_ffff);
    write_reg(CFG_STALE_LIMIT, 32'hffff_ffff);
    write_reg(CFG_GRID_LIMIT, 32'h7fff_ffff);
    send_sample(meter_word(32'd70, 1'b1, 32'hffff_ffff, 32'h7fff_ffff, 1'b1,
                           1'b1, 32'hffff_ffff, 32'h7fff_ffff, 1'b1));
    settle();
    write_reg(CFG_DETECT_MODE, {30'd0, MODE_BAD});
    send_sample(single_word(32'd80, 1'b1, 32'd0, 16'd0));
    settle();

    // ---- random part: four idle/stall phases, settings change between runs ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin                      // flat out
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin                      // sparse sender
          send_idle_pct = 83;
          stall_pct     = 0;
        end
        2: begin                      // slow receiver
          send_idle_pct = 0;
          stall_pct     = 83;
        end
        default: begin                // light noise on both sides
          send_idle_pct = 9;
          stall_pct     = 9;
        end
      endcase
      sent = 0;
      while (sent < 170) begin
        // registers only move once the pipe has drained
        settle();
        setting = random_setting();
        apply_setting(setting);
        // time steps scaled to the debounce so candidates get to settle
        if (setting.debounce_time != 32'd0 && setting.debounce_time <= 32'd40)
          step_ms = setting.debounce_time / 2 + 1;
        else
          step_ms = 50;
        n = $urandom_range(45, 15);
        repeat (n) begin
          send_sample(random_sample());
          sent++;
        end
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (fail_count == 0)
      $display("power_source_detect_debounce_tb passed");
    else
      $display("power_source_detect_debounce_tb failed");
    $finish;
  end

endmodule
